// File: src/assert_macros.svh
// Assertion macros used by the top level of the cache lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define AST_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Check that post holds in the cycle after pre.
`define AST_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/sac_pkg.sv
// Shared types and constants of the set-associative cache lookup block.
`default_nettype none

package sac_pkg;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;

    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 64;
    localparam int CNT_W     = 32;
    localparam int KIND_W    = 2;
    localparam int OUT_W     = 104;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_FETCH  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_STORE  = 2'd2,
        KIND_MODIFY = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    localparam logic [3:0] RST_SET_BITS    = 4'd4;
    localparam logic [3:0] RST_WAYS        = 4'd1;
    localparam logic [4:0] RST_OFFSET_BITS = 5'd4;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
    } lookup_res_t;

endpackage

`default_nettype wire

// File: src/sac_way_select.sv
// Way search, fill or victim choice and LRU order update for one set.
`default_nettype none

module sac_way_select
    import sac_pkg::*;
#(
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  wire logic [3:0]                        ways_in_use,
    input  wire logic [TAG_W-1:0]                  tag,
    input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]    tags_in,
    input  wire logic [MAX_WAYS-1:0]               valid_in,
    input  wire logic [MAX_WAYS-1:0][WAY_W-1:0]    order_in,
    output logic      [MAX_WAYS-1:0][TAG_W-1:0]    tags_out,
    output logic      [MAX_WAYS-1:0]               valid_out,
    output logic      [MAX_WAYS-1:0][WAY_W-1:0]    order_out,
    output lookup_res_t                            res
);

    logic [4:0]       ways_eff;
    logic             hit_found;
    logic             empty_found;
    logic             pos_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] victim_way;
    logic             victim_found;
    logic [WAY_W-1:0] way;
    logic [WAY_W-1:0] pos;

    always_comb begin
        if (ways_in_use == 4'd0) begin
            ways_eff = 5'd1;
        end else if (5'(ways_in_use) > 5'(MAX_WAYS)) begin
            ways_eff = 5'(MAX_WAYS);
        end else begin
            ways_eff = 5'(ways_in_use);
        end
    end

    // Search the ways in use: tag match, then first empty way, then LRU victim.
    always_comb begin
        hit_found    = 1'b0;
        hit_way      = '0;
        empty_found  = 1'b0;
        empty_way    = '0;
        victim_found = 1'b0;
        victim_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (5'(w) < ways_eff) begin
                if (!hit_found && valid_in[w] && tags_in[w] == tag) begin
                    hit_found = 1'b1;
                    hit_way   = WAY_W'(w);
                end
                if (!empty_found && !valid_in[w]) begin
                    empty_found = 1'b1;
                    empty_way   = WAY_W'(w);
                end
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!victim_found && 5'(order_in[i]) < ways_eff) begin
                victim_found = 1'b1;
                victim_way   = order_in[i];
            end
        end
    end

    always_comb begin
        if (hit_found) begin
            way = hit_way;
        end else if (empty_found) begin
            way = empty_way;
        end else begin
            way = victim_way;
        end
        res.hit   = hit_found;
        res.miss  = !hit_found;
        res.evict = !hit_found && !empty_found;
    end

    // Install the tag on a miss.
    always_comb begin
        tags_out  = tags_in;
        valid_out = valid_in;
        if (!hit_found) begin
            tags_out[way] = tag;
        end
        valid_out[way] = 1'b1;
    end

    // Move the touched way to the most recent end of the order.
    always_comb begin
        pos_found = 1'b0;
        pos       = WAY_W'(MAX_WAYS - 1);
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!pos_found && order_in[i] == way) begin
                pos_found = 1'b1;
                pos       = WAY_W'(i);
            end
        end
        for (int i = 0; i < MAX_WAYS - 1; i++) begin
            order_out[i] = (WAY_W'(i) < pos) ? order_in[i] : order_in[i+1];
        end
        order_out[MAX_WAYS-1] = way;
    end

endmodule

`default_nettype wire

// File: src/set_assoc_cache_lru_sim.sv
// Top level of the set-associative cache lookup block with LRU replacement.
//
// Usage:
//   Input transfers carry the access kind on s_tuser and the byte address on
//   s_tdata. Each load or store yields one result transfer, a modify yields two
//   (the second with m_tlast high), and an instruction fetch yields none.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata while idle.
// Timing:
//   Each lookup is a read-modify-write of one row of the set memory: the row is
//   read into rd_row_reg when the item is accepted, and it is written back, with
//   the result registered, once the output register is free. A modify does a
//   second lookup on the forwarded row; a fetch does no lookup. One item is in
//   flight at a time: a new item is accepted only after the last has finished.
// Reset:
//   aresetn clears the counters, restores the reset configuration, then a
//   clearing pass initializes every row (lines invalid, identity LRU order);
//   s_tready stays low during it.
// Backpressure:
//   The result sits in an output register. While m_tready is low the next item
//   may still be accepted and its row read; its write-back waits for the slot.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_lru_sim
    import sac_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // kind [1:0]
    input  wire logic [KIND_W-1:0]     s_tuser,
    // access_address [63:0]
    input  wire logic [ADDR_W-1:0]     s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // was_hit [0], was_miss [1], was_eviction [2], total_hits [34:3],
    // total_misses [66:35], total_evictions [98:67], zero fill [103:99]
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata
);

    localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAGS_W       = MAX_WAYS * TAG_W;
    localparam int ORDER_W      = MAX_WAYS * WAY_W;
    localparam int ROW_W        = TAGS_W + MAX_WAYS + ORDER_W;

    // Configuration registers.
    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [4:0] offset_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg    <= RST_SET_BITS;
            ways_reg        <= RST_WAYS;
            offset_bits_reg <= RST_OFFSET_BITS;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[3:0];
                CFG_WAYS:        ways_reg        <= cfg_wdata[3:0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Address split: set index from the incoming address, tag from the held one.
    logic [4:0]        set_bits_eff;
    logic [SET_W:0]    set_mask;
    logic [ADDR_W-1:0] addr_above;
    logic [SET_W-1:0]  set_in;
    logic [5:0]        tag_shift;
    logic [ADDR_W-1:0] addr_reg;
    logic [TAG_W-1:0]  tag;

    always_comb begin
        set_bits_eff = (5'(set_bits_reg) > 5'(SET_BITS_MAX)) ? 5'(SET_BITS_MAX)
                                                              : 5'(set_bits_reg);
        set_mask     = ((SET_W+1)'(1) << set_bits_eff) - (SET_W+1)'(1);
        addr_above   = s_tdata >> offset_bits_reg;
        set_in       = addr_above[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift    = 6'(offset_bits_reg) + 6'(set_bits_eff);
        tag          = addr_reg >> tag_shift;
    end

    // Control.
    state_t           state_reg;
    state_t           state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] set_reg;
    kind_t            kind_reg;
    logic             second_reg;
    logic             accept;
    logic             out_free;
    logic             step;
    logic             last_lookup;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid || m_tready;
    assign step        = (state_reg == ST_LOOKUP) && out_free;
    assign last_lookup = (kind_reg != KIND_MODIFY) || second_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && kind_t'(s_tuser) != KIND_FETCH) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (step && last_lookup) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            second_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (step) begin
                second_reg <= !last_lookup;
            end
        end
    end

    // Hold the accepted item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_tdata;
            kind_reg <= kind_t'(s_tuser);
            set_reg  <= set_in;
        end
    end

    // Row memory: {order, valid, tags} per set, registered read.
    logic [ROW_W-1:0] mem [MAX_SETS];
    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] fwd_row_reg;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_new;
    logic [ROW_W-1:0] init_row;
    logic [ROW_W-1:0] wr_row;
    logic [SET_W-1:0] wr_addr;
    logic             wr_en;
    logic [MAX_WAYS-1:0][WAY_W-1:0] order_init;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            order_init[i] = WAY_W'(i);
        end
        init_row = {order_init, {MAX_WAYS{1'b0}}, {TAGS_W{1'b0}}};
        wr_en    = (state_reg == ST_CLEAR) || step;
        wr_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
        wr_row   = (state_reg == ST_CLEAR) ? init_row : row_new;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (accept) begin
            rd_row_reg <= mem[set_in];
        end
    end

    // Forward the written row to the second lookup of a modify.
    always_ff @(posedge aclk) begin
        if (step) begin
            fwd_row_reg <= row_new;
        end
    end

    assign row_cur = second_reg ? fwd_row_reg : rd_row_reg;

    logic [MAX_WAYS-1:0][TAG_W-1:0] cur_tags;
    logic [MAX_WAYS-1:0]            cur_valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0] cur_order;
    logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;
    logic [MAX_WAYS-1:0]            new_valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0] new_order;
    lookup_res_t                    res;

    assign cur_tags  = row_cur[TAGS_W-1:0];
    assign cur_valid = row_cur[TAGS_W +: MAX_WAYS];
    assign cur_order = row_cur[TAGS_W + MAX_WAYS +: ORDER_W];
    assign row_new   = {new_order, new_valid, new_tags};

    sac_way_select #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W)
    ) u_way_select (
        .ways_in_use (ways_reg),
        .tag         (tag),
        .tags_in     (cur_tags),
        .valid_in    (cur_valid),
        .order_in    (cur_order),
        .tags_out    (new_tags),
        .valid_out   (new_valid),
        .order_out   (new_order),
        .res         (res)
    );

    // Running totals and the output register.
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] misses_reg;
    logic [CNT_W-1:0] evicts_reg;
    logic [CNT_W-1:0] hits_next;
    logic [CNT_W-1:0] misses_next;
    logic [CNT_W-1:0] evicts_next;
    logic             m_tvalid_reg;
    logic             m_tlast_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    always_comb begin
        hits_next   = hits_reg + CNT_W'(res.hit);
        misses_next = misses_reg + CNT_W'(res.miss);
        evicts_next = evicts_reg + CNT_W'(res.evict);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg     <= '0;
            misses_reg   <= '0;
            evicts_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            evicts_reg   <= evicts_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tlast_reg <= last_lookup;
            m_tdata_reg <= {5'd0, evicts_next, misses_next, hits_next,
                            res.evict, res.miss, res.hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    `AST_SAME(a_hit_xor_miss, aclk, aresetn, m_tvalid, (m_tdata[0] ^ m_tdata[1]),
              "result must be exactly one of hit and miss")
    `AST_SAME(a_evict_on_miss, aclk, aresetn, m_tvalid && m_tdata[2], m_tdata[1],
              "eviction reported without a miss")
    `AST_SAME(a_second_modify, aclk, aresetn, second_reg,
              (kind_reg == KIND_MODIFY) && (state_reg == ST_LOOKUP),
              "second lookup outside a modify access")
    `AST_NEXT(a_hit_count, aclk, aresetn, step && res.hit,
              hits_reg == $past(hits_reg) + CNT_W'(1),
              "hit total did not advance on a hit")
    `AST_SAME(a_no_accept_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready,
              "input accepted during the clearing pass")

endmodule

`default_nettype wire
